/* sv/tpd_pkg.sv */
// Shared types, constants and helpers for the triac phase dimmer.
package tpd_pkg;

    // Line buffer length in bytes before the parse restarts
    localparam int LINE_LENGTH = 10;
    localparam int LB_W        = (LINE_LENGTH > 2) ? $clog2(LINE_LENGTH) : 1;

    // Field and register widths
    localparam int HALF_W  = 15;
    localparam int PULSE_W = 10;
    localparam int LEVEL_W = 4;
    localparam int CNT_W   = 15;
    localparam int Q_W     = 12;
    localparam int R_W     = 4;

    // Reset values of the configuration registers, delay constants and level limits
    localparam int HALF_RESET  = 8333;
    localparam int PULSE_RESET = 10;
    localparam int SPAN_OFFSET = 200;
    localparam int DELAY_BASE  = 100;
    localparam int MAX_LEVEL   = 10;
    localparam int SAT_LEVEL   = 11;

    // Span split into quotient and remainder by nine, worked out at elaboration
    localparam int SPAN_RESET   = HALF_RESET - SPAN_OFFSET;
    localparam int SPAN_Q_RESET = SPAN_RESET / 9;
    localparam int SPAN_R_RESET = SPAN_RESET % 9;

    // Reciprocal of nine: exact for every 15-bit dividend
    localparam int RECIP_DIV9  = 29128;
    localparam int RECIP_SHIFT = 18;

    // Character codes
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_EDGE = 2'd1,
        REQ_BYTE = 2'd2
    } req_t;

    typedef enum logic {
        CFG_HALF  = 1'b0,
        CFG_PULSE = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_DELAY = 2'd1,
        PH_PULSE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        PS_SPACE  = 2'd0,
        PS_SIGN   = 2'd1,
        PS_DIGITS = 2'd2,
        PS_DONE   = 2'd3
    } parse_t;

    // Configuration as the phase controller sees it
    typedef struct packed {
        logic [Q_W-1:0]   span_q;
        logic [R_W-1:0]   span_r;
        logic [CNT_W-1:0] pulse_len;
    } cfg_t;

    // Gate status after an item
    typedef struct packed {
        logic gate;
        logic busy;
    } ph_status_t;

    // Divide a product of at most 72 by nine with a row of compares
    function automatic logic [3:0] div9_small(input logic [6:0] p);
        logic [3:0] cnt;
        cnt = '0;
        for (int i = 1; i <= 8; i++) begin
            if (p >= 7'(9 * i)) begin
                cnt = cnt + 4'd1;
            end
        end
        return cnt;
    endfunction

endpackage

/* sv/tpd_cfg_regs.sv */
// Configuration registers: half period kept as span quotient and remainder by nine.
module tpd_cfg_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [tpd_pkg::HALF_W-1:0] cfg_data,
    output tpd_pkg::cfg_t             cfg
);
    import tpd_pkg::*;

    logic [Q_W-1:0]     span_q_reg;
    logic [R_W-1:0]     span_r_reg;
    logic [PULSE_W-1:0] pulse_reg;

    logic [HALF_W-1:0]   span;
    logic [2*HALF_W-1:0] recip_prod;
    logic [Q_W-1:0]      q_est;
    logic [HALF_W-1:0]   rem_est;
    logic [Q_W-1:0]      q_next;
    logic [R_W-1:0]      r_next;

    // Split the span by nine with a reciprocal multiply and one correction
    always_comb
    begin
        span = (cfg_data > HALF_W'(SPAN_OFFSET)) ? cfg_data - HALF_W'(SPAN_OFFSET) : '0;
        recip_prod = (2*HALF_W)'(span) * (2*HALF_W)'(RECIP_DIV9);
        q_est = recip_prod[RECIP_SHIFT +: Q_W];
        rem_est = span - ((HALF_W'(q_est) << 3) + HALF_W'(q_est));
        if (rem_est >= HALF_W'(9))
        begin
            q_next = q_est + Q_W'(1);
            r_next = R_W'(rem_est - HALF_W'(9));
        end
        else
        begin
            q_next = q_est;
            r_next = R_W'(rem_est);
        end
    end

    // Capture writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_q_reg <= Q_W'(SPAN_Q_RESET);
            span_r_reg <= R_W'(SPAN_R_RESET);
            pulse_reg  <= PULSE_W'(PULSE_RESET);
        end
        else if (cfg_we)
        begin
            if (cfg_idx_t'(cfg_index) == CFG_HALF)
            begin
                span_q_reg <= q_next;
                span_r_reg <= r_next;
            end
            else
            begin
                pulse_reg <= cfg_data[PULSE_W-1:0];
            end
        end
    end

    // A zero width counts as one tick
    assign cfg.span_q    = span_q_reg;
    assign cfg.span_r    = span_r_reg;
    assign cfg.pulse_len = (pulse_reg == '0) ? CNT_W'(1) : CNT_W'(pulse_reg);

endmodule

/* sv/tpd_level_parser.sv */
// Serial line parser that turns received text into the dimming level.
module tpd_level_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  tpd_pkg::req_t               req,
    input  logic [7:0]                  rx_data,
    output logic [tpd_pkg::LEVEL_W-1:0] level,
    output logic [tpd_pkg::LEVEL_W-1:0] level_next
);
    import tpd_pkg::*;

    parse_t             stage_reg, stage_next;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] digit_reg, digit_next;
    logic               neg_reg, neg_next;
    logic [LB_W-1:0]    line_reg, line_next;

    logic       take_byte;
    logic       is_term;
    logic       is_digit;
    logic       is_space;
    logic       is_sign;
    logic       line_full;
    logic       line_ok;
    logic [6:0] acc;

    // Classify the byte
    always_comb
    begin
        take_byte = fire && (req == REQ_BYTE);
        is_term   = (rx_data == CH_LF) || (rx_data == CH_CR);
        is_digit  = (rx_data >= CH_ZERO) && (rx_data <= CH_NINE);
        is_space  = (rx_data == CH_SPACE) || (rx_data == CH_TAB) ||
                    (rx_data == CH_VT) || (rx_data == CH_FF);
        is_sign   = (rx_data == CH_PLUS) || (rx_data == CH_MINUS);
        line_full = (line_reg == LB_W'(LINE_LENGTH - 1));
        line_ok   = (digit_reg <= LEVEL_W'(MAX_LEVEL)) && !(neg_reg && (digit_reg != '0));
        acc       = 7'(digit_reg) * 7'd10 + {3'b000, rx_data[3:0]};
    end

    // Next parse stage
    always_comb
    begin
        stage_next = stage_reg;
        if (take_byte)
        begin
            if (is_term || line_full)
            begin
                stage_next = PS_SPACE;
            end
            else if (stage_reg != PS_DONE)
            begin
                priority if (is_digit)
                    stage_next = PS_DIGITS;
                else if (stage_reg == PS_SPACE && is_space)
                    stage_next = PS_SPACE;
                else if (stage_reg == PS_SPACE && is_sign)
                    stage_next = PS_SIGN;
                else
                    stage_next = PS_DONE;
            end
        end
    end

    // Value, sign, byte count and accepted level
    always_comb
    begin
        digit_next = digit_reg;
        neg_next   = neg_reg;
        line_next  = line_reg;
        level_next = level_reg;
        if (take_byte)
        begin
            if (is_term)
            begin
                if (line_ok)
                begin
                    level_next = neg_reg ? '0 : digit_reg;
                end
                digit_next = '0;
                neg_next   = 1'b0;
                line_next  = '0;
            end
            else
            begin
                if (stage_reg != PS_DONE)
                begin
                    if (is_digit)
                    begin
                        digit_next = (acc > 7'(SAT_LEVEL)) ? LEVEL_W'(SAT_LEVEL) : acc[LEVEL_W-1:0];
                    end
                    else if (stage_reg == PS_SPACE && is_sign)
                    begin
                        neg_next = (rx_data == CH_MINUS);
                    end
                end
                if (line_full)
                begin
                    digit_next = '0;
                    neg_next   = 1'b0;
                    line_next  = '0;
                end
                else
                begin
                    line_next = line_reg + LB_W'(1);
                end
            end
        end
    end

    // Hold parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= PS_SPACE;
            level_reg <= '0;
            digit_reg <= '0;
            neg_reg   <= 1'b0;
            line_reg  <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
            level_reg <= level_next;
            digit_reg <= digit_next;
            neg_reg   <= neg_next;
            line_reg  <= line_next;
        end
    end

    assign level = level_reg;

endmodule

/* sv/tpd_phase_ctrl.sv */
// Phase controller: firing delay, gate pulse and tick counting.
module tpd_phase_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  tpd_pkg::req_t               req,
    input  logic [tpd_pkg::LEVEL_W-1:0] level,
    input  tpd_pkg::cfg_t               cfg,
    output tpd_pkg::ph_status_t         status_next
);
    import tpd_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [LEVEL_W-1:0]       lvl_m1;
    logic [LEVEL_W+Q_W-1:0]   whole_part;
    logic [LEVEL_W+R_W-1:0]   frac_prod;
    logic [3:0]               frac_part;
    logic [LEVEL_W+Q_W-1:0]   delay_sum;
    logic [CNT_W-1:0]         delay;
    logic [CNT_W-1:0]         cnt_dec;

    // Firing delay: (level-1)*span/9 + base, from the span split by nine
    always_comb
    begin
        lvl_m1     = level - LEVEL_W'(1);
        whole_part = (LEVEL_W+Q_W)'(lvl_m1) * (LEVEL_W+Q_W)'(cfg.span_q);
        frac_prod  = (LEVEL_W+R_W)'(lvl_m1) * (LEVEL_W+R_W)'(cfg.span_r);
        frac_part  = div9_small(frac_prod[6:0]);
        delay_sum  = whole_part + (LEVEL_W+Q_W)'(frac_part) + (LEVEL_W+Q_W)'(DELAY_BASE);
        delay      = delay_sum[CNT_W-1:0];
        cnt_dec    = (cnt_reg != '0) ? cnt_reg - CNT_W'(1) : '0;
    end

    // Next phase and count
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        if (fire)
        begin
            unique case (req)
                REQ_TICK:
                begin
                    if (phase_reg == PH_DELAY)
                    begin
                        cnt_next = cnt_dec;
                        if (cnt_dec == '0)
                        begin
                            phase_next = PH_PULSE;
                            cnt_next   = cfg.pulse_len;
                        end
                    end
                    else if (phase_reg == PH_PULSE)
                    begin
                        cnt_next = cnt_dec;
                        if (cnt_dec == '0)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
                REQ_EDGE:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        if (level == '0)
                        begin
                            phase_next = PH_PULSE;
                            cnt_next   = cfg.pulse_len;
                        end
                        else
                        begin
                            phase_next = PH_DELAY;
                            cnt_next   = delay;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Status seen after this item
    always_comb
    begin
        status_next.gate = (phase_next == PH_PULSE);
        status_next.busy = (phase_next != PH_IDLE);
    end

    // Hold phase and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* sv/triac_phase_dimmer_with_serial_level.sv */
// Top level of the triac phase dimmer with serial level input.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | in        | in_valid / in_stall  | req_type, rx_byte
//  out     | out       | out_valid / out_stall| gate_on, dim_level, busy_res
//  cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per clock while the result channel is not stalled; each item passes
// through the input register, then the state update into the result register.
// The state update is a single pass through the parser and the phase
// controller; the firing delay uses a 4x12 and a 4x4 multiply and a 72/9 compare row.
// Reset clears the line parser, the level, the phase and the count, and loads
// the register defaults. cfg_ready is always high.
// A stalled result holds the pipe; in_stall rises only when the input
// register is full and the result register cannot move.
module triac_phase_dimmer_with_serial_level (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   req_type,
    input  logic [7:0]                   rx_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         gate_on,
    output logic [tpd_pkg::LEVEL_W-1:0]  dim_level,
    output logic                         busy_res,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [tpd_pkg::HALF_W-1:0]   cfg_data
);
    import tpd_pkg::*;

    logic               in_valid_reg;
    logic [1:0]         req_reg;
    logic [7:0]         byte_reg;
    logic               out_valid_reg;
    logic               gate_reg;
    logic [LEVEL_W-1:0] level_out_reg;
    logic               busy_reg;

    logic               advance;
    logic               fire;
    logic               in_xfer;
    cfg_t               cfg;
    logic [LEVEL_W-1:0] level_cur;
    logic [LEVEL_W-1:0] level_next;
    ph_status_t         status_next;

    // Pipe control
    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_reg  <= req_type;
            byte_reg <= rx_byte;
        end
    end

    tpd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tpd_level_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .req        (req_t'(req_reg)),
        .rx_data    (byte_reg),
        .level      (level_cur),
        .level_next (level_next)
    );

    tpd_phase_ctrl u_phase (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .req         (req_t'(req_reg)),
        .level       (level_cur),
        .cfg         (cfg),
        .status_next (status_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            gate_reg      <= status_next.gate;
            level_out_reg <= level_next;
            busy_reg      <= status_next.busy;
        end
    end

    assign out_valid = out_valid_reg;
    assign gate_on   = gate_reg;
    assign dim_level = level_out_reg;
    assign busy_res  = busy_reg;

    // Gate drive only during a busy phase
    a_gate_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!gate_on || busy_res))
        else $error("gate driven while idle");

    // Reported level stays in range
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (dim_level <= LEVEL_W'(MAX_LEVEL)))
        else $error("level out of range");

    // Stall only with a held item behind a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

    // A stalled result leaves the state untouched
    a_hold_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(level_cur))
        else $error("level changed while the result was stalled");

endmodule

/* test/triac_phase_dimmer_with_serial_level_tb.sv */
// Self-checking testbench for the triac phase dimmer with serial level input.
`timescale 1ns / 100ps

module triac_phase_dimmer_with_serial_level_tb;
    import tpd_pkg::*;

    // Request code that the block does not decode
    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    // Cycles without any transfer before the run is declared hung
    localparam int         IDLE_LIMIT   = 4000;
    // Cycles to watch for stray results once everything has arrived
    localparam int         DRAIN_CYCLES = 8;
    // Divisor of the firing delay span
    localparam int         DELAY_STEPS  = 9;
    localparam int         NUM_SETTINGS = 6;

    localparam logic [7:0] SPACE_CHARS [4] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};

    // Register settings and item counts of the random phases
    localparam int HALF_SET  [NUM_SETTINGS] = '{1000, 0, 32767, 20000, 200, 8333};
    localparam int PULSE_SET [NUM_SETTINGS] = '{1, 0, 1023, 37, 5, 1000};
    localparam int ITEM_SET  [NUM_SETTINGS] = '{220, 200, 150, 230, 200, 230};

    // Tracks parser, level and gate phase, and checks each status in order
    class dimmer_tracker;
        typedef struct {
            logic               gate;
            logic [LEVEL_W-1:0] level;
            logic               busy;
        } status_t;

        status_t            expected_status[$];
        logic [HALF_W-1:0]  half_period;
        logic [PULSE_W-1:0] pulse_width;
        logic [LEVEL_W-1:0] level;
        phase_t             phase;
        logic [CNT_W-1:0]   tick_count;
        logic [3:0]         digit_value;
        logic               negative;
        parse_t             stage;
        int                 line_count;
        logic               gate;
        int                 errors;
        int                 results;
        int                 pulses;
        int                 level_loads;

        function new();
            half_period = HALF_W'(HALF_RESET);
            pulse_width = PULSE_W'(PULSE_RESET);
            level       = '0;
            phase       = PH_IDLE;
            tick_count  = '0;
            gate        = 1'b0;
            errors      = 0;
            results     = 0;
            pulses      = 0;
            level_loads = 0;
            restart_line();
        endfunction

        function void restart_line();
            digit_value = '0;
            negative    = 1'b0;
            stage       = PS_SPACE;
            line_count  = 0;
        endfunction

        // Raise the gate and load the width; a zero width counts as one
        function void start_pulse();
            gate       = 1'b1;
            phase      = PH_PULSE;
            tick_count = (pulse_width == 0) ? CNT_W'(1) : CNT_W'(pulse_width);
            pulses++;
        endfunction

        function void write_register(cfg_idx_t idx, logic [HALF_W-1:0] data);
            if (idx == CFG_HALF)
                half_period = data;
            else
                pulse_width = data[PULSE_W-1:0];
        endfunction

        // Advance on one accepted item and queue the status it leaves
        function void note_input(logic [1:0] req, logic [7:0] b);
            status_t s;
            int      span;
            int      v;
            case (req)
                REQ_TICK:
                begin
                    if (phase != PH_IDLE)
                    begin
                        if (tick_count != 0)
                            tick_count--;
                        if (tick_count == 0)
                        begin
                            if (phase == PH_DELAY)
                                start_pulse();
                            else
                            begin
                                gate  = 1'b0;
                                phase = PH_IDLE;
                            end
                        end
                    end
                end
                REQ_EDGE:
                begin
                    // edges while busy are dropped
                    if (phase == PH_IDLE)
                    begin
                        if (level == 0)
                            start_pulse();
                        else
                        begin
                            span = (half_period > SPAN_OFFSET) ?
                                   int'(half_period) - SPAN_OFFSET : 0;
                            tick_count = CNT_W'((int'(level) - 1) * span / DELAY_STEPS
                                                + DELAY_BASE);
                            gate  = 1'b0;
                            phase = PH_DELAY;
                        end
                    end
                end
                REQ_BYTE:
                begin
                    if (b == CH_LF || b == CH_CR)
                    begin
                        // reject negatives other than zero and saturated values
                        if (digit_value <= MAX_LEVEL && !(negative && digit_value != 0))
                        begin
                            level = negative ? '0 : digit_value;
                            level_loads++;
                        end
                        restart_line();
                    end
                    else
                    begin
                        if (stage != PS_DONE)
                        begin
                            if (b >= CH_ZERO && b <= CH_NINE)
                            begin
                                v = int'(digit_value) * 10 + int'(b - CH_ZERO);
                                digit_value = (v > SAT_LEVEL) ? 4'(SAT_LEVEL) : 4'(v);
                                stage = PS_DIGITS;
                            end
                            else if (stage == PS_SPACE && (b == CH_PLUS || b == CH_MINUS))
                            begin
                                negative = (b == CH_MINUS);
                                stage    = PS_SIGN;
                            end
                            else if (!(stage == PS_SPACE && (b == CH_SPACE || b == CH_TAB ||
                                                             b == CH_VT || b == CH_FF)))
                                stage = PS_DONE;
                        end
                        // restart an overlong line
                        line_count++;
                        if (line_count >= LINE_LENGTH)
                            restart_line();
                    end
                end
                default:
                    ;
            endcase
            s.gate  = gate;
            s.level = level;
            s.busy  = (phase != PH_IDLE);
            expected_status.push_back(s);
        endfunction

        // Compare one result transfer with the oldest queued status
        function void check_result(logic g, logic [LEVEL_W-1:0] lv, logic busy);
            status_t s;
            results++;
            if (expected_status.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result gate_on %0b dim_level %0d busy_res %0b",
                         $time, g, lv, busy);
                return;
            end
            s = expected_status.pop_front();
            if (g !== s.gate)
            begin
                errors++;
                $display("%0t: gate_on expected %0b actual %0b", $time, s.gate, g);
            end
            if (lv !== s.level)
            begin
                errors++;
                $display("%0t: dim_level expected %0d actual %0d", $time, s.level, lv);
            end
            if (busy !== s.busy)
            begin
                errors++;
                $display("%0t: busy_res expected %0b actual %0b", $time, s.busy, busy);
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [1:0]         req_type  = REQ_TICK;
    logic [7:0]         rx_byte   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               gate_on;
    logic [LEVEL_W-1:0] dim_level;
    logic               busy_res;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = CFG_HALF;
    logic [HALF_W-1:0]  cfg_data  = '0;

    dimmer_tracker tracker;
    int            send_gap_pct   = 0;
    int            recv_stall_pct = 0;
    int            items_sent     = 0;
    int            settings_used  = 0;
    int            quiet_cycles   = 0;
    logic [7:0]    pending_text[$];

    triac_phase_dimmer_with_serial_level dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .gate_on   (gate_on),
        .dim_level (dim_level),
        .busy_res  (busy_res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result channel at random
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Check result transfers and watch for a hung handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                tracker.check_result(gate_on, dim_level, busy_res);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one item after random gaps and hold it until the transfer
    task automatic send_item(input logic [1:0] req, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_input(req, b);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(REQ_BYTE, s[i]);
    endtask

    // Hold off the sender until every queued status has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (tracker.expected_status.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic program_registers(input logic [HALF_W-1:0] half,
                                     input logic [HALF_W-1:0] pulse);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_HALF;
        cfg_data  <= half;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.write_register(CFG_HALF, half);
        @(negedge clk);
        cfg_index <= CFG_PULSE;
        cfg_data  <= pulse;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.write_register(CFG_PULSE, pulse);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Queue one serial line: mostly levels, some overflow, saturation, empty lines and noise
    function automatic void compose_line();
        int kind;
        int v;
        kind = $urandom_range(0, 9);
        if (kind <= 4)
        begin
            repeat ($urandom_range(0, 2))
                pending_text.push_back(SPACE_CHARS[$urandom_range(0, 3)]);
            case ($urandom_range(0, 5))
                0: pending_text.push_back(CH_PLUS);
                1: pending_text.push_back(CH_MINUS);
                default: ;
            endcase
            v = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 2) :
                                               $urandom_range(0, MAX_LEVEL);
            if ($urandom_range(0, 4) == 0)
                pending_text.push_back(CH_ZERO);
            if (v >= 10)
                pending_text.push_back(8'(CH_ZERO + v / 10));
            pending_text.push_back(8'(CH_ZERO + v % 10));
            if ($urandom_range(0, 4) == 0)
                pending_text.push_back(8'($urandom));
        end
        else if (kind == 5)
        begin
            pending_text.push_back(8'(CH_ZERO + $urandom_range(1, 9)));
            repeat ($urandom_range(1, 2))
                pending_text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end
        else if (kind == 7)
        begin
            // overlong line with no terminator
            repeat ($urandom_range(LINE_LENGTH, LINE_LENGTH + 4))
                pending_text.push_back(8'($urandom_range(CH_SPACE, 8'h7E)));
            return;
        end
        else if (kind >= 8)
        begin
            repeat ($urandom_range(1, 12))
                pending_text.push_back(8'($urandom));
        end
        pending_text.push_back(($urandom_range(0, 1) != 0) ? CH_LF : CH_CR);
    endfunction

    // Mostly ticks so that delays and pulses run out, plus edges, unused codes and text
    task automatic send_random(input int count);
        int         pick;
        logic [7:0] b;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            b    = 8'($urandom);
            if (pick < 70)
                send_item(REQ_TICK, b);
            else if (pick < 78)
                send_item(REQ_EDGE, b);
            else if (pick < 80)
                send_item(REQ_UNUSED, b);
            else
            begin
                if (pending_text.size() == 0)
                    compose_line();
                send_item(REQ_BYTE, pending_text.pop_front());
            end
        end
    endtask

    initial
    begin
        tracker = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Sender idles lightly, receiver stalls heavily
        send_gap_pct   = 28;
        recv_stall_pct = 71;

        // Tick while idle, fire at level zero, edge while busy, unused code
        send_item(REQ_TICK, 8'hFF);
        send_item(REQ_EDGE, 8'h00);
        send_item(REQ_EDGE, 8'h00);
        send_item(REQ_UNUSED, 8'hA5);
        // Signed level ended by a non-digit, then minus zero
        send_text(" +1");
        send_item(REQ_BYTE, 8'hFF);
        send_item(REQ_BYTE, CH_LF);
        send_text("\t-0\r");
        // Saturated value ended by NUL, negative level, plain level, empty line
        send_text("12");
        send_item(REQ_BYTE, 8'h00);
        send_item(REQ_BYTE, CH_CR);
        send_text("-5\n7\n");
        send_item(REQ_BYTE, CH_LF);

        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            drain_results();
            if (p == 2)
            begin
                send_gap_pct   = 71;
                recv_stall_pct = 28;
            end
            else if (p == 4)
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            program_registers(HALF_W'(HALF_SET[p]), HALF_W'(PULSE_SET[p]));
            send_random(ITEM_SET[p]);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d ticks, edges and bytes under %0d register settings,",
                 items_sent, settings_used + 1);
        $display("checked %0d results: %0d gate pulses, %0d level lines accepted",
                 tracker.results, tracker.pulses, tracker.level_loads);
        if (tracker.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
sv/tpd_pkg.sv
sv/tpd_cfg_regs.sv
sv/tpd_level_parser.sv
sv/tpd_phase_ctrl.sv
sv/triac_phase_dimmer_with_serial_level.sv
test/triac_phase_dimmer_with_serial_level_tb.sv
